[hw/rtl/rc4fb_pkg.sv]
`default_nettype none
package rc4fb_pkg;

    // S-box geometry (fixed by the cipher)
    localparam int TABLE_SIZE = 256;
    localparam int TABLE_AW   = 8;
    localparam int CNT_W      = 9;

    // seq_slot codes
    localparam logic [1:0] SLOT_DATA = 2'd0;
    localparam logic [1:0] SLOT_SEQ_HI = 2'd1;
    localparam logic [1:0] SLOT_SEQ_LO = 2'd2;

    // mode codes
    localparam logic MODE_KEY = 1'b0;
    localparam logic MODE_PAYLOAD = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic acc;       // input word accepted this cycle
        logic ks_init;   // fill base table with identity
        logic ks_rd_i;   // schedule: read S[i] and key[k]
        logic ks_rd_j;   // schedule: update j, read S[j]
        logic ks_wr_i;   // schedule: write S[i]
        logic ks_wr_j;   // schedule: write S[j], advance i and k
        logic copy;      // copy base table into work table
        logic rd_x;      // step: x++, read W[x]
        logic rd_y;      // step: y += sx, read W[y]
        logic wr_x;      // step: write W[x], read W[sx+sy]
        logic wr_y;      // step: write W[y]
        logic out_load;  // load output register
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic idx_255;   // sweep counter at last table entry
        logic idx_256;   // sweep counter past last table entry
    } t_sts;

endpackage
`default_nettype wire

[hw/rtl/rc4fb_ram.sv]
`default_nettype none
module rc4fb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port; rdata holds when not read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/rc4fb_dpath.sv]
`default_nettype none
module rc4fb_dpath #(
    parameter int KEY_MAX = 256,
    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rc4fb_pkg::t_cmd   i_cmd,
    output rc4fb_pkg::t_sts        o_sts,
    input  wire logic              i_mode,
    input  wire logic [7:0]        i_data,
    input  wire logic              i_first,
    input  wire logic              i_last,
    input  wire logic [1:0]        i_slot,
    output logic [7:0]             o_out_byte,
    output logic                   o_out_last
);
    import rc4fb_pkg::*;

    // control state
    logic [CNT_W-1:0]    r_key_cnt;
    logic [CNT_W-1:0]    r_key_len;
    logic [15:0]         r_seq;
    logic [TABLE_AW-1:0] r_x, r_y;
    logic [CNT_W-1:0]    r_idx;
    logic [TABLE_AW-1:0] r_j;
    logic [KW-1:0]       r_k;
    // payload
    logic [7:0]          r_sx, r_sy, r_t, r_p;
    logic                r_last;

    logic [15:0]         n_seq;
    logic [7:0]          n_p;
    logic                key_room;
    logic [CNT_W-1:0]    key_inc;
    logic [CNT_W-1:0]    k_plus;
    logic [TABLE_AW-1:0] j_new, y_new, t_new, ks_byte;

    // memory ports
    logic                base_we, base_re, work_we, work_re, key_we, key_re;
    logic [TABLE_AW-1:0] base_waddr, base_raddr, work_waddr, work_raddr;
    logic [7:0]          base_wdata, base_rdata, work_wdata, work_rdata, key_rdata;

    rc4fb_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_base (
        .i_clk(i_clk), .i_we(base_we), .i_waddr(base_waddr), .i_wdata(base_wdata),
        .i_re(base_re), .i_raddr(base_raddr), .o_rdata(base_rdata)
    );

    rc4fb_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_work (
        .i_clk(i_clk), .i_we(work_we), .i_waddr(work_waddr), .i_wdata(work_wdata),
        .i_re(work_re), .i_raddr(work_raddr), .o_rdata(work_rdata)
    );

    rc4fb_ram #(.WIDTH(8), .DEPTH(KEY_MAX)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(r_key_cnt[KW-1:0]), .i_wdata(i_data),
        .i_re(key_re), .i_raddr(r_k), .o_rdata(key_rdata)
    );

    // key byte bookkeeping
    assign key_room = (r_key_cnt < CNT_W'(KEY_MAX));
    assign key_inc  = key_room ? (r_key_cnt + CNT_W'(1)) : r_key_cnt;
    assign key_we   = i_cmd.acc && (i_mode == MODE_KEY) && key_room;
    assign key_re   = i_cmd.ks_rd_i;
    assign k_plus   = CNT_W'(r_k) + CNT_W'(1);

    // sequence and plaintext selection at accept
    always_comb begin
        n_seq = i_first ? (r_seq + 16'd1) : r_seq;
        case (i_slot)
            SLOT_SEQ_HI: n_p = n_seq[15:8];
            SLOT_SEQ_LO: n_p = n_seq[7:0];
            default:     n_p = i_data;
        endcase
    end

    assign j_new = r_j + base_rdata + key_rdata;
    assign y_new = r_y + work_rdata;
    assign t_new = r_sx + work_rdata;

    // keystream byte after the swap: W[y] = sx, W[x] = sy, else old W[t]
    always_comb begin
        if (r_t == r_y) begin
            ks_byte = r_sx;
        end else if (r_t == r_x) begin
            ks_byte = r_sy;
        end else begin
            ks_byte = work_rdata;
        end
    end

    // base table port
    always_comb begin
        base_we    = 1'b0;
        base_waddr = r_idx[TABLE_AW-1:0];
        base_wdata = r_idx[TABLE_AW-1:0];
        base_re    = 1'b0;
        base_raddr = r_idx[TABLE_AW-1:0];
        if (i_cmd.ks_init) begin
            base_we = 1'b1;
        end
        if (i_cmd.ks_rd_i) begin
            base_re = 1'b1;
        end
        if (i_cmd.ks_rd_j) begin
            base_re    = 1'b1;
            base_raddr = j_new;
        end
        if (i_cmd.ks_wr_i) begin
            base_we    = 1'b1;
            base_wdata = base_rdata;
        end
        if (i_cmd.ks_wr_j) begin
            base_we    = 1'b1;
            base_waddr = r_j;
            base_wdata = r_sx;
        end
        if (i_cmd.copy) begin
            base_re = !r_idx[CNT_W-1];
        end
    end

    // work table port
    always_comb begin
        work_we    = 1'b0;
        work_waddr = r_x;
        work_wdata = work_rdata;
        work_re    = 1'b0;
        work_raddr = r_x + 8'd1;
        if (i_cmd.copy) begin
            work_we    = (r_idx != '0);
            work_waddr = r_idx[TABLE_AW-1:0] - 8'd1;
            work_wdata = base_rdata;
        end
        if (i_cmd.rd_x) begin
            work_re = 1'b1;
        end
        if (i_cmd.rd_y) begin
            work_re    = 1'b1;
            work_raddr = y_new;
        end
        if (i_cmd.wr_x) begin
            work_we    = 1'b1;
            work_re    = 1'b1;
            work_raddr = t_new;
        end
        if (i_cmd.wr_y) begin
            work_we    = 1'b1;
            work_waddr = r_y;
            work_wdata = r_sx;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_cnt <= '0;
            r_key_len <= CNT_W'(1);
            r_seq     <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_idx     <= '0;
            r_j       <= '0;
            r_k       <= '0;
        end else begin
            if (i_cmd.acc) begin
                r_idx <= '0;
                if (i_mode == MODE_KEY) begin
                    if (i_last) begin
                        r_key_len <= key_inc;
                        r_key_cnt <= '0;
                        r_seq     <= '0;
                    end else begin
                        r_key_cnt <= key_inc;
                    end
                end else begin
                    r_seq <= n_seq;
                    if (i_first) begin
                        r_x <= '0;
                        r_y <= '0;
                    end
                end
            end
            if (i_cmd.ks_init) begin
                r_idx <= o_sts.idx_255 ? '0 : (r_idx + CNT_W'(1));
                r_j   <= '0;
                r_k   <= '0;
            end
            if (i_cmd.ks_rd_j) begin
                r_j <= j_new;
            end
            if (i_cmd.ks_wr_j) begin
                r_idx <= r_idx + CNT_W'(1);
                r_k   <= (k_plus == r_key_len) ? '0 : KW'(k_plus);
            end
            if (i_cmd.copy) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.rd_x) begin
                r_x <= r_x + 8'd1;
            end
            if (i_cmd.rd_y) begin
                r_y <= y_new;
            end
            if (i_cmd.out_load) begin
                r_y <= r_y + r_p;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_p    <= n_p;
            r_last <= i_last;
        end
        if (i_cmd.ks_rd_j) begin
            r_sx <= base_rdata;
        end
        if (i_cmd.rd_y) begin
            r_sx <= work_rdata;
        end
        if (i_cmd.wr_x) begin
            r_sy <= work_rdata;
            r_t  <= t_new;
        end
        if (i_cmd.out_load) begin
            o_out_byte <= r_p ^ ks_byte;
            o_out_last <= r_last;
        end
    end

    assign o_sts.idx_255 = (r_idx == CNT_W'(TABLE_SIZE - 1));
    assign o_sts.idx_256 = r_idx[CNT_W-1];

endmodule
`default_nettype wire

[hw/rtl/rc4fb_ctrl.sv]
`default_nettype none
module rc4fb_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_valid,
    output logic                 o_s_ready,
    input  wire logic            i_mode,
    input  wire logic            i_first,
    input  wire logic            i_last,
    output logic                 o_m_valid,
    input  wire logic            i_m_ready,
    output rc4fb_pkg::t_cmd      o_cmd,
    input  wire rc4fb_pkg::t_sts i_sts
);
    import rc4fb_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_KS_INIT = 4'd1;
    localparam logic [3:0] ST_KS_RD_I = 4'd2;
    localparam logic [3:0] ST_KS_RD_J = 4'd3;
    localparam logic [3:0] ST_KS_WR_I = 4'd4;
    localparam logic [3:0] ST_KS_WR_J = 4'd5;
    localparam logic [3:0] ST_COPY    = 4'd6;
    localparam logic [3:0] ST_RD_X    = 4'd7;
    localparam logic [3:0] ST_RD_Y    = 4'd8;
    localparam logic [3:0] ST_WR_X    = 4'd9;
    localparam logic [3:0] ST_WR_Y    = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_m_valid;
    logic       acc, out_free;

    assign o_s_ready = (r_state == ST_IDLE);
    assign acc       = i_s_valid && o_s_ready;
    assign out_free  = !r_m_valid || i_m_ready;
    assign o_m_valid = r_m_valid;

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.acc      = acc;
        o_cmd.ks_init  = (r_state == ST_KS_INIT);
        o_cmd.ks_rd_i  = (r_state == ST_KS_RD_I);
        o_cmd.ks_rd_j  = (r_state == ST_KS_RD_J);
        o_cmd.ks_wr_i  = (r_state == ST_KS_WR_I);
        o_cmd.ks_wr_j  = (r_state == ST_KS_WR_J);
        o_cmd.copy     = (r_state == ST_COPY);
        o_cmd.rd_x     = (r_state == ST_RD_X);
        o_cmd.rd_y     = (r_state == ST_RD_Y);
        o_cmd.wr_x     = (r_state == ST_WR_X);
        o_cmd.wr_y     = (r_state == ST_WR_Y);
        o_cmd.out_load = (r_state == ST_WR_Y) && out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (i_mode == MODE_KEY) begin
                        n_state = i_last ? ST_KS_INIT : ST_IDLE;
                    end else begin
                        n_state = i_first ? ST_COPY : ST_RD_X;
                    end
                end
            end
            ST_KS_INIT: n_state = i_sts.idx_255 ? ST_KS_RD_I : ST_KS_INIT;
            ST_KS_RD_I: n_state = ST_KS_RD_J;
            ST_KS_RD_J: n_state = ST_KS_WR_I;
            ST_KS_WR_I: n_state = ST_KS_WR_J;
            ST_KS_WR_J: n_state = i_sts.idx_255 ? ST_IDLE : ST_KS_RD_I;
            ST_COPY:    n_state = i_sts.idx_256 ? ST_RD_X : ST_COPY;
            ST_RD_X:    n_state = ST_RD_Y;
            ST_RD_Y:    n_state = ST_WR_X;
            ST_WR_X:    n_state = ST_WR_Y;
            ST_WR_Y:    n_state = out_free ? ST_IDLE : ST_WR_Y;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // the W[x] write step is always followed by the W[y] write step
    a_wrx_to_wry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR_X) |=> (r_state == ST_WR_Y))
        else $error("swap write sequence broken");

    // key byte without last mark produces nothing and stays idle
    a_key_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_mode == MODE_KEY) && !i_last) |=> (r_state == ST_IDLE))
        else $error("plain key byte left idle");

    // payload accept goes straight to copy or to the step
    a_pay_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_mode == MODE_PAYLOAD)) |=> ((r_state == ST_COPY) || (r_state == ST_RD_X)))
        else $error("payload word did not start processing");

    // a loaded result shows up as valid next cycle and the block is back idle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_m_valid && (r_state == ST_IDLE)))
        else $error("result load lost");

endmodule
`default_nettype wire

[hw/rtl/rc4_variant_feedback_cipher.sv]
// RC4 with plaintext feedback, one session.
// Payload word: after accept, steps rd_x, rd_y, wr_x, wr_y load the output register, and no
// new word is taken until idle again; a stalled output holds the last step until it drains.
// A packet's first word first copies the base table into the work table (one RAM port each).
// Last key word: identity fill, then per S-box entry ks_rd_i, ks_rd_j, ks_wr_i, ks_wr_j; no result.
// Synchronous active-low reset clears control state, key count, indices and sequence;
// the table and key RAMs are not cleared and hold garbage until written.
`default_nettype none
module rc4_variant_feedback_cipher #(
    parameter int KEY_MAX = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // slave side
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic [3:0] s_tuser,   // [0] mode, [1] first, [3:2] seq_slot
    input  wire logic       s_tlast,   // last
    // master side
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast    // out_last
);
    import rc4fb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rc4fb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .o_s_ready (s_tready),
        .i_mode    (s_tuser[0]),
        .i_first   (s_tuser[1]),
        .i_last    (s_tlast),
        .o_m_valid (m_tvalid),
        .i_m_ready (m_tready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    rc4fb_dpath #(.KEY_MAX(KEY_MAX)) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_mode     (s_tuser[0]),
        .i_data     (s_tdata),
        .i_first    (s_tuser[1]),
        .i_last     (s_tlast),
        .i_slot     (s_tuser[3:2]),
        .o_out_byte (m_tdata),
        .o_out_last (m_tlast)
    );

endmodule
`default_nettype wire
